/* src/ppcd_pkg.sv */
// Shared types and constants for the path pair conflict detector.
// Used by every module under src; depends on nothing else.
`default_nettype none

package ppcd_pkg;

    localparam int MAX_PATH_LEN = 256;
    localparam int COORD_BITS   = 10;
    localparam int AGENT_BITS   = 8;
    localparam int TIME_W       = 8;
    localparam int CELL_W       = 2 * COORD_BITS;
    localparam int ADDR_W       = $clog2(MAX_PATH_LEN);
    localparam int LEN_W        = $clog2(MAX_PATH_LEN + 1);

    // A path cell: row in the upper half, column in the lower half.
    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [AGENT_BITS-1:0] agent;
    } t_path_info;

    typedef struct packed {
        logic              found;
        logic              is_edge;
        logic [TIME_W-1:0] ctime;
        t_cell             from_cell;
        t_cell             to_cell;
    } t_result;

endpackage

`default_nettype wire

/* src/path_pair_conflict_detector_core.sv */
// Top level of the path pair conflict detector: stream ports, two path memories
// and the scan sequencer. Depends on ppcd_pkg, ppcd_path_mem and ppcd_scan.
//
//  Channel | Direction | Payload
//  s_axis  | in        | tdata: agent, row, col; tuser: mode; tlast: last
//  m_axis  | out       | tdata: agents, time, from/to cells; tuser: found, is_edge
//
// A path cell is written straight into its memory as it is taken.
// The last cell of a second path starts a scan that reads both path memories in time
// order through the single read port of each; it ends early on an empty path or at
// the first conflict. No cell is taken meanwhile.
// Reset clears lengths, owners and control state; the memories need no clearing pass.
// A result waiting in the output register does not stop the input; only a
// further check stalls until that register is free.
`default_nettype none

module path_pair_conflict_detector_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // agent[7:0], row[17:8], col[27:18]
    input  wire logic [0:0]  s_axis_tuser,   // mode[0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // first_agent[7:0], second_agent[15:8], conflict_time[23:16], from_row[33:24],
    // from_col[43:34], to_row[53:44], to_col[63:54]
    output logic [63:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // found[0], is_edge[1]
);
    import ppcd_pkg::*;

    logic                  in_xfer, wr_first, wr_second, start;
    logic [AGENT_BITS-1:0] in_agent;
    t_cell                 in_cell;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;
    t_cell                 rd_a, rd_b;
    t_path_info            info_a, info_b;
    t_result               result;
    logic [AGENT_BITS-1:0] out_fa, out_sa;
    logic                  idle;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign wr_first  = in_xfer && !s_axis_tuser[0];
    assign wr_second = in_xfer && s_axis_tuser[0];
    assign start     = wr_second && s_axis_tlast;
    assign in_agent  = s_axis_tdata[7:0];
    assign in_cell   = {s_axis_tdata[17:8], s_axis_tdata[27:18]};

    ppcd_path_mem u_mem_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_first),
        .i_agent   (in_agent),
        .i_cell    (in_cell),
        .i_last    (s_axis_tlast),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a),
        .o_info    (info_a)
    );

    ppcd_path_mem u_mem_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_second),
        .i_agent   (in_agent),
        .i_cell    (in_cell),
        .i_last    (s_axis_tlast),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b),
        .o_info    (info_b)
    );

    ppcd_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_first        (info_a),
        .i_second       (info_b),
        .i_rd_a         (rd_a),
        .i_rd_b         (rd_b),
        .i_out_ready    (m_axis_tready),
        .o_idle         (idle),
        .o_rd_en        (rd_en),
        .o_rd_addr_a    (rd_addr_a),
        .o_rd_addr_b    (rd_addr_b),
        .o_out_valid    (m_axis_tvalid),
        .o_result       (result),
        .o_first_agent  (out_fa),
        .o_second_agent (out_sa)
    );

    assign s_axis_tready = idle;

    assign m_axis_tdata = {result.to_cell[COORD_BITS-1:0],
                           result.to_cell[CELL_W-1:COORD_BITS],
                           result.from_cell[COORD_BITS-1:0],
                           result.from_cell[CELL_W-1:COORD_BITS],
                           result.ctime,
                           out_sa,
                           out_fa};
    assign m_axis_tuser = {result.is_edge, result.found};

endmodule

`default_nettype wire

/* src/ppcd_path_mem.sv */
// Cell store for one path: a synchronous memory plus its length, owner and closed flag.
// Depends on ppcd_pkg.
`default_nettype none

module ppcd_path_mem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [ppcd_pkg::AGENT_BITS-1:0] i_agent,
    input  wire ppcd_pkg::t_cell                 i_cell,
    input  wire logic                            i_last,
    input  wire logic                            i_rd_en,
    input  wire logic [ppcd_pkg::ADDR_W-1:0]     i_rd_addr,
    output ppcd_pkg::t_cell                      o_rd_data,
    output ppcd_pkg::t_path_info                 o_info
);
    import ppcd_pkg::*;

    t_cell                 r_mem [MAX_PATH_LEN];
    t_cell                 r_rd_data;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [AGENT_BITS-1:0] r_agent, n_agent;
    logic                  r_closed, n_closed;
    logic [LEN_W-1:0]      eff_len;
    logic                  room;

    // A closed path restarts at length zero on its next cell.
    always_comb begin
        eff_len  = r_closed ? '0 : r_len;
        room     = (eff_len < LEN_W'(MAX_PATH_LEN));
        n_len    = r_len;
        n_agent  = r_agent;
        n_closed = r_closed;
        if (i_wr) begin
            n_closed = i_last;
            n_len    = eff_len;
            if (room) begin
                n_len = eff_len + 1'b1;
                if (eff_len == '0) begin
                    n_agent = i_agent;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_agent  <= '0;
            r_closed <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_agent  <= n_agent;
            r_closed <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && room) begin
            r_mem[eff_len[ADDR_W-1:0]] <= i_cell;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_info.len   = r_len;
    assign o_info.agent = r_agent;

endmodule

`default_nettype wire

/* src/ppcd_scan.sv */
// Scan sequencer: walks both path memories in time order, compares cells and
// holds the result in the output register. Depends on ppcd_pkg.
`default_nettype none

module ppcd_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire ppcd_pkg::t_path_info            i_first,
    input  wire ppcd_pkg::t_path_info            i_second,
    input  wire ppcd_pkg::t_cell                 i_rd_a,
    input  wire ppcd_pkg::t_cell                 i_rd_b,
    input  wire logic                            i_out_ready,
    output logic                                 o_idle,
    output logic                                 o_rd_en,
    output logic [ppcd_pkg::ADDR_W-1:0]          o_rd_addr_a,
    output logic [ppcd_pkg::ADDR_W-1:0]          o_rd_addr_b,
    output logic                                 o_out_valid,
    output ppcd_pkg::t_result                    o_result,
    output logic [ppcd_pkg::AGENT_BITS-1:0]      o_first_agent,
    output logic [ppcd_pkg::AGENT_BITS-1:0]      o_second_agent
);
    import ppcd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [LEN_W-1:0]      r_iss;
    logic                  r_iss_done;
    logic                  r_dv;
    logic [LEN_W-1:0]      r_didx;
    t_cell                 r_prev_a, r_prev_b;
    t_result               r_res;
    logic                  r_out_vld, n_out_vld;
    t_result               r_out_res;
    logic [AGENT_BITS-1:0] r_out_fa, r_out_sa;

    logic [LEN_W-1:0]      la, lb, end_idx, ka, kb;
    logic                  empty, vertex, edge_hit, hit, last_data, finish, issue;
    logic                  out_free, load_out;
    t_result               res_now;

    always_comb begin
        la      = i_first.len;
        lb      = i_second.len;
        end_idx = (la > lb) ? la : lb;
        empty   = (la == '0) || (lb == '0);
        // Data for index i pairs with the held cells of index i-1: the check is for time i-1.
        vertex   = (r_didx != '0) && (r_prev_a == r_prev_b);
        edge_hit = (r_didx != '0) && (r_didx < la) && (r_didx < lb)
                   && (r_prev_a == i_rd_b) && (i_rd_a == r_prev_b);
        hit       = r_dv && (vertex || edge_hit);
        last_data = r_dv && (r_didx == end_idx);
        finish    = (r_state == ST_SCAN) && (empty || hit || last_data);
        issue     = (r_state == ST_SCAN) && !finish && !r_iss_done;

        // A path that has ended is read at its last cell.
        ka = (r_iss < la) ? r_iss : la - 1'b1;
        kb = (r_iss < lb) ? r_iss : lb - 1'b1;

        res_now = '0;
        if (hit && !empty) begin
            res_now.found     = 1'b1;
            res_now.is_edge   = !vertex;
            res_now.ctime     = TIME_W'(r_didx - 1'b1);
            res_now.from_cell = r_prev_a;
            res_now.to_cell   = vertex ? r_prev_a : i_rd_a;
        end

        out_free = !r_out_vld || i_out_ready;
        load_out = 1'b0;
        n_state  = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    load_out = out_free;
                    n_state  = out_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_vld = load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_iss_done <= 1'b0;
            r_dv       <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dv      <= issue;
            r_out_vld <= n_out_vld;
            if (r_state == ST_IDLE) begin
                r_iss_done <= 1'b0;
            end else if (issue) begin
                r_iss_done <= (r_iss == end_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_iss <= '0;
        end else if (issue) begin
            r_iss <= r_iss + 1'b1;
        end
        r_didx <= r_iss;
        if (r_dv) begin
            r_prev_a <= i_rd_a;
            r_prev_b <= i_rd_b;
        end
        if (finish) begin
            r_res <= res_now;
        end
        if (load_out) begin
            r_out_res <= (r_state == ST_SCAN) ? res_now : r_res;
            r_out_fa  <= i_first.agent;
            r_out_sa  <= i_second.agent;
        end
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_rd_en        = issue;
    assign o_rd_addr_a    = ka[ADDR_W-1:0];
    assign o_rd_addr_b    = kb[ADDR_W-1:0];
    assign o_out_valid    = r_out_vld;
    assign o_result       = r_out_res;
    assign o_first_agent  = r_out_fa;
    assign o_second_agent = r_out_sa;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("check started while the scan was busy");

    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> r_out_vld)
        else $error("scan waiting although the output register is free");

    a_data_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_SCAN))
        else $error("read data returned outside a scan");

    a_edge_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_res.is_edge) |-> r_out_res.found)
        else $error("swap conflict flagged without a conflict");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_res.found) |->
            ((r_out_res.ctime == '0) && (r_out_res.from_cell == '0)
             && (r_out_res.to_cell == '0)))
        else $error("result without conflict carries nonzero fields");
`endif

endmodule

`default_nettype wire

/* tb/ppcd_conflict_checker.sv */
// Scoreboard for the path pair conflict detector: watches both stream channels,
// keeps its own copy of the two paths and checks every reported result.
// Depends on ppcd_pkg; also holds the small package shared with the testbench top.
`timescale 1ns / 100ps

package ppcd_tb_pkg;

    typedef enum logic {
        PATH_FIRST  = 1'b0,
        PATH_SECOND = 1'b1
    } t_path_sel;

endpackage

module ppcd_conflict_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // agent[7:0], row[17:8], col[27:18]
    input  wire logic [0:0]  s_axis_tuser,   // mode[0]
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // first_agent[7:0], second_agent[15:8], conflict_time[23:16], from_row[33:24],
    // from_col[43:34], to_row[53:44], to_col[63:54]
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,   // found[0], is_edge[1]
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checks,
    output int               o_conflicts,
    output int               o_swaps
);
    import ppcd_pkg::*;
    import ppcd_tb_pkg::*;

    typedef struct packed {
        logic                  found;
        logic [AGENT_BITS-1:0] first_agent;
        logic [AGENT_BITS-1:0] second_agent;
        logic [TIME_W-1:0]     ctime;
        logic                  is_edge;
        logic [COORD_BITS-1:0] from_row;
        logic [COORD_BITS-1:0] from_col;
        logic [COORD_BITS-1:0] to_row;
        logic [COORD_BITS-1:0] to_col;
    } t_conflict_report;

    t_cell                 path_cells  [2][MAX_PATH_LEN];
    int unsigned           path_len    [2];
    logic [AGENT_BITS-1:0] path_owner  [2];
    bit                    path_closed [2];

    t_conflict_report expected_reports[$];
    t_conflict_report want;
    t_conflict_report got;
    t_path_sel        sel;

    int fail_count = 0;
    int pending    = 0;
    int checks     = 0;
    int conflicts  = 0;
    int swaps      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checks     = checks;
    assign o_conflicts  = conflicts;
    assign o_swaps      = swaps;

    // A cell arriving after the path was closed starts that path afresh; cells
    // beyond capacity are dropped but their last flag still closes the path.
    task automatic store_cell(input t_path_sel p, input logic [AGENT_BITS-1:0] id,
                              input t_cell c, input bit fin);
        if (path_closed[p]) begin
            path_len[p]    = 0;
            path_closed[p] = 1'b0;
        end
        if (path_len[p] < MAX_PATH_LEN) begin
            if (path_len[p] == 0)
                path_owner[p] = id;
            path_cells[p][path_len[p]] = c;
            path_len[p]++;
        end
        if (fin)
            path_closed[p] = 1'b1;
    endtask

    // An agent whose path has ended stays on its final cell.
    function automatic t_cell cell_of(input t_path_sel p, input int unsigned t);
        return (t < path_len[p]) ? path_cells[p][t] : path_cells[p][path_len[p] - 1];
    endfunction

    function automatic t_conflict_report scan_paths();
        t_conflict_report r;
        int unsigned      la;
        int unsigned      lb;
        int unsigned      horizon;
        t_cell            a;
        t_cell            b;
        t_cell            a_next;
        bit               swap;
        r              = '0;
        r.first_agent  = path_owner[PATH_FIRST];
        r.second_agent = path_owner[PATH_SECOND];
        la             = path_len[PATH_FIRST];
        lb             = path_len[PATH_SECOND];
        if (la == 0 || lb == 0)
            return r;
        horizon = (la > lb) ? la : lb;
        for (int unsigned t = 0; t < horizon; t++) begin
            a      = cell_of(PATH_FIRST, t);
            b      = cell_of(PATH_SECOND, t);
            a_next = a;
            swap   = 1'b0;
            if (a != b) begin
                // A swap only counts while both agents are still moving.
                if (t + 1 < la && t + 1 < lb && a == path_cells[PATH_SECOND][t + 1]
                        && b == path_cells[PATH_FIRST][t + 1]) begin
                    swap   = 1'b1;
                    a_next = path_cells[PATH_FIRST][t + 1];
                end else begin
                    continue;
                end
            end
            r.found    = 1'b1;
            r.is_edge  = swap;
            r.ctime    = t[TIME_W-1:0];
            r.from_row = a[CELL_W-1:COORD_BITS];
            r.from_col = a[COORD_BITS-1:0];
            r.to_row   = a_next[CELL_W-1:COORD_BITS];
            r.to_col   = a_next[COORD_BITS-1:0];
            return r;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val,
                     act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                path_len[p]    = 0;
                path_owner[p]  = '0;
                path_closed[p] = 1'b0;
            end
            expected_reports.delete();
            pending = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found        = m_axis_tuser[0];
                got.is_edge      = m_axis_tuser[1];
                got.first_agent  = m_axis_tdata[7:0];
                got.second_agent = m_axis_tdata[15:8];
                got.ctime        = m_axis_tdata[23:16];
                got.from_row     = m_axis_tdata[33:24];
                got.from_col     = m_axis_tdata[43:34];
                got.to_row       = m_axis_tdata[53:44];
                got.to_col       = m_axis_tdata[63:54];
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with nothing expected, got tuser %b tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    pending--;
                    checks++;
                    if (want.found)
                        conflicts++;
                    if (want.is_edge)
                        swaps++;
                    check_field("found", 16'(want.found), 16'(got.found));
                    check_field("first_agent", 16'(want.first_agent),
                                16'(got.first_agent));
                    check_field("second_agent", 16'(want.second_agent),
                                16'(got.second_agent));
                    check_field("conflict_time", 16'(want.ctime), 16'(got.ctime));
                    check_field("is_edge", 16'(want.is_edge), 16'(got.is_edge));
                    check_field("from_row", 16'(want.from_row), 16'(got.from_row));
                    check_field("from_col", 16'(want.from_col), 16'(got.from_col));
                    check_field("to_row", 16'(want.to_row), 16'(got.to_row));
                    check_field("to_col", 16'(want.to_col), 16'(got.to_col));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sel = t_path_sel'(s_axis_tuser[0]);
                store_cell(sel, s_axis_tdata[7:0],
                           {s_axis_tdata[17:8], s_axis_tdata[27:18]}, s_axis_tlast);
                // Only the closing cell of a second path triggers a scan.
                if (sel == PATH_SECOND && s_axis_tlast) begin
                    expected_reports = {expected_reports, scan_paths()};
                    pending++;
                end
            end
        end
    end

endmodule

/* tb/path_pair_conflict_detector_core_tb.sv */
// Testbench top for the path pair conflict detector: clock, reset, path stimulus
// and the verdict. Uses ppcd_pkg, ppcd_tb_pkg, ppcd_conflict_checker and the core.
`timescale 1ns / 100ps

module path_pair_conflict_detector_core_tb;

    import ppcd_pkg::*;
    import ppcd_tb_pkg::*;

    typedef enum int {
        MOVE_STAY,
        MOVE_NORTH,
        MOVE_SOUTH,
        MOVE_WEST,
        MOVE_EAST
    } t_move;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // agent[7:0], row[17:8], col[27:18]
    logic [0:0]  s_axis_tuser  = '0;   // mode[0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // first_agent[7:0], second_agent[15:8], conflict_time[23:16], from_row[33:24],
    // from_col[43:34], to_row[53:44], to_col[63:54]
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;         // found[0], is_edge[1]

    int fail_count;
    int pending;
    int checks;
    int conflicts;
    int swaps;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cells_sent  = 0;

    int tx_phase_pct [3] = '{35, 68, 0};
    int rx_phase_pct [3] = '{68, 35, 0};

    t_cell                 first_route[$];
    t_cell                 second_route[$];
    logic [AGENT_BITS-1:0] first_owner;

    path_pair_conflict_detector_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ppcd_conflict_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checks      (checks),
        .o_conflicts   (conflicts),
        .o_swaps       (swaps)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d results still outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_cell(input t_path_sel p, input logic [AGENT_BITS-1:0] id,
                             input t_cell c, input bit fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, c[COORD_BITS-1:0], c[CELL_W-1:COORD_BITS], id};
        s_axis_tuser  <= p;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        cells_sent++;
    endtask

    task automatic send_route(input t_path_sel p, input logic [AGENT_BITS-1:0] id);
        int    n;
        t_cell c;
        n = (p == PATH_FIRST) ? first_route.size() : second_route.size();
        for (int i = 0; i < n; i++) begin
            c = (p == PATH_FIRST) ? first_route[i] : second_route[i];
            send_cell(p, id, c, i == n - 1);
        end
    endtask

    // The input goes quiet first so the last cell is not taken again.
    // Sampling on the falling edge keeps this clear of the checker's own update.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // One step of a walk; coordinates wrap so the top bits get exercised too.
    function automatic t_cell step_cell(input t_cell c);
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] q;
        r = c[CELL_W-1:COORD_BITS];
        q = c[COORD_BITS-1:0];
        case (t_move'($urandom_range(MOVE_EAST)))
            MOVE_NORTH: r = r - 1'b1;
            MOVE_SOUTH: r = r + 1'b1;
            MOVE_WEST:  q = q - 1'b1;
            MOVE_EAST:  q = q + 1'b1;
            default:    ;
        endcase
        return {r, q};
    endfunction

    function automatic int route_len();
        return ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
    endfunction

    task automatic random_pair();
        int    n1;
        int    n2;
        int    t;
        int    pick;
        t_cell c;
        if (first_route.size() == 0 || $urandom_range(99) < 75) begin
            n1          = route_len();
            first_owner = AGENT_BITS'($urandom);
            c           = t_cell'($urandom);
            first_route.delete();
            for (int i = 0; i < n1; i++) begin
                first_route = {first_route, c};
                c = step_cell(c);
            end
            send_route(PATH_FIRST, first_owner);
        end
        n1 = first_route.size();
        n2 = route_len();
        // Starting next to the first agent makes chance collisions common.
        c = ($urandom_range(99) < 80) ? first_route[$urandom_range(n1 - 1)]
                                      : t_cell'($urandom);
        second_route.delete();
        for (int i = 0; i < n2; i++) begin
            c = step_cell(c);
            second_route = {second_route, c};
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            t               = $urandom_range(n2 - 1);
            second_route[t] = first_route[(t < n1) ? t : n1 - 1];
        end else if (pick < 60 && n1 > 1 && n2 > 1) begin
            t                   = $urandom_range(((n1 < n2) ? n1 : n2) - 2);
            second_route[t]     = first_route[t + 1];
            second_route[t + 1] = first_route[t];
        end
        send_route(PATH_SECOND, AGENT_BITS'($urandom));
    endtask

    // Unstructured cells: interleaved paths, stray closes, open paths.
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_cell(t_path_sel'($urandom_range(1)), AGENT_BITS'($urandom),
                      t_cell'($urandom), $urandom_range(3) == 0);
        first_route.delete();
    endtask

    initial begin
        int goal;
        tx_idle_pct = tx_phase_pct[0];
        rx_idle_pct = rx_phase_pct[0];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No first path yet: the check must report nothing found.
        send_cell(PATH_SECOND, 8'hFF, {10'd1023, 10'd1023}, 1'b1);
        // A closed first path gives no result; the second agent meets it waiting.
        send_cell(PATH_FIRST, 8'hFF, {10'd1023, 10'd1023}, 1'b1);
        send_cell(PATH_SECOND, 8'h00, {10'd0, 10'd0}, 1'b0);
        send_cell(PATH_SECOND, 8'h00, {10'd1023, 10'd1023}, 1'b1);
        // Swap at the very first step.
        send_cell(PATH_FIRST, 8'h5A, {10'd0, 10'd0}, 1'b0);
        send_cell(PATH_FIRST, 8'h5A, {10'd0, 10'd1}, 1'b0);
        send_cell(PATH_FIRST, 8'h5A, {10'd0, 10'd2}, 1'b1);
        send_cell(PATH_SECOND, 8'hA5, {10'd0, 10'd1}, 1'b0);
        send_cell(PATH_SECOND, 8'hA5, {10'd0, 10'd0}, 1'b1);
        // The first path is kept: a vertex clash at time two, then no clash.
        send_cell(PATH_SECOND, 8'h3C, {10'd5, 10'd5}, 1'b0);
        send_cell(PATH_SECOND, 8'h3C, {10'd5, 10'd6}, 1'b0);
        send_cell(PATH_SECOND, 8'h3C, {10'd0, 10'd2}, 1'b1);
        send_cell(PATH_SECOND, 8'hC3, {10'd9, 10'd9}, 1'b1);
        // A one-cell second path cannot swap, so the clash is a vertex one later.
        send_cell(PATH_SECOND, 8'h81, {10'd0, 10'd1}, 1'b1);
        // A new first path replaces the closed one; swap on extreme coordinates.
        send_cell(PATH_FIRST, 8'h00, {10'd1023, 10'd0}, 1'b0);
        send_cell(PATH_FIRST, 8'h00, {10'd0, 10'd1023}, 1'b1);
        send_cell(PATH_SECOND, 8'h80, {10'd0, 10'd1023}, 1'b0);
        send_cell(PATH_SECOND, 8'h80, {10'd1023, 10'd0}, 1'b1);

        // Both paths overrun capacity; the dropped closing cells still count.
        for (int t = 0; t < MAX_PATH_LEN + 4; t++)
            send_cell(PATH_FIRST, 8'h11, {COORD_BITS'(t), 10'd7}, t == MAX_PATH_LEN + 3);
        for (int t = 0; t < MAX_PATH_LEN + 2; t++)
            send_cell(PATH_SECOND, 8'hEE,
                      {COORD_BITS'(t), (t == MAX_PATH_LEN - 1) ? 10'd7 : 10'd9},
                      t == MAX_PATH_LEN + 1);
        first_route.delete();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_phase_pct[ph];
            rx_idle_pct = rx_phase_pct[ph];
            goal        = cells_sent + 220;
            while (cells_sent < goal) begin
                if ($urandom_range(99) < 88)
                    random_pair();
                else
                    noise_burst();
            end
            // Hold the input back once until the output side has caught up.
            if (ph == 0)
                wait_drained();
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge i_clk);

        $display("Sent %0d path cells under three idling regimes; %0d checks compared,",
                 cells_sent, checks);
        $display("%0d of them with a conflict and %0d of those swaps.", conflicts, swaps);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* path_pair_conflict_detector_core.f */
src/ppcd_pkg.sv
src/ppcd_path_mem.sv
src/ppcd_scan.sv
src/path_pair_conflict_detector_core.sv
tb/ppcd_conflict_checker.sv
tb/path_pair_conflict_detector_core_tb.sv
